/* hdl/psta_pkg.sv */
// Shared types and constants for the per-symbol trade aggregator.
// No dependencies.
package psta_pkg;

	localparam int TimeW = 37;
	localparam int KeyW = 24;
	localparam int VolW = 48;
	localparam int NotW = 64;
	localparam int PriceW = 31;
	localparam logic [TimeW-1:0] DayReset = 37'd86400000000;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_NEW = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [36:0] trade_time;
		logic [23:0] ticker;
		logic signed [31:0] quantity;
		logic signed [31:0] price;
	} trade_t;

	typedef struct packed {
		logic [1:0] status;
		logic [23:0] ticker_out;
		logic [36:0] largest_gap;
		logic [47:0] volume_total;
		logic [30:0] weighted_price;
		logic [30:0] top_price;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RD, S_CMP, S_NEWE, S_UPD, S_WR, S_DIV, S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic check;
		logic search_start;
		logic search_step;
		logic alloc;
		logic update;
		logic write;
		logic div_start;
		logic div_step;
		logic set_reject;
		logic set_full;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic hit;
		logic search_last;
		logic table_full;
		logic div_done;
	} stat_t;

endpackage

/* hdl/per_symbol_trade_aggregator.sv */
// Top level of the per-symbol trade aggregator.
// Depends on psta_pkg, psta_ctrl, psta_dp.
// One trade in, one result out. A known symbol is updated once the search reaches its slot;
// a new symbol searches every used entry before it is allocated. The symbol search
// reads one table entry per cycle from a single-port memory and the VWAP quotient
// comes from a 64-step serial divider.
// Rejected and table-full trades skip the divider. The result sits in an output
// register, so the next trade is taken while it waits.
module per_symbol_trade_aggregator #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [36:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  psta_pkg::trade_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output psta_pkg::result_t out_data
);
	import psta_pkg::*;

	cmd_t cmd;
	stat_t st;

	psta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
	);

	psta_dp #(.Entries(TABLE_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.trade(in_data), .cmd(cmd), .st(st), .result(out_data)
	);
endmodule

/* hdl/psta_ctrl.sv */
// Controller state machine for the per-symbol trade aggregator.
// Depends on psta_pkg.
module psta_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  psta_pkg::stat_t st,
	output psta_pkg::cmd_t cmd
);
	import psta_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// result register frees as soon as it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				if (st.bad) begin
					cmd.set_reject = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.search_start = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (st.hit) begin
					cmd.update = 1'b1;
					state_d = S_WR;
				end else if (st.search_last) begin
					if (st.table_full) begin
						cmd.set_full = 1'b1;
						state_d = S_OUT;
					end else begin
						state_d = S_NEWE;
					end
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			S_NEWE: begin
				cmd.alloc = 1'b1;
				state_d = S_WR;
			end
			S_UPD: state_d = S_WR;
			S_WR: begin
				cmd.write = 1'b1;
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) state_d = S_OUT;
				else cmd.div_step = 1'b1;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.write || cmd.div_step)) else $error("busy while ready");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == S_IDLE) else $error("output load out of order");
`endif
endmodule

/* hdl/psta_dp.sv */
// Datapath: symbol table memory, linear search, update and serial divider.
// Depends on psta_pkg.
module psta_dp #(
	parameter int Entries = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [36:0] cfg_data,
	input  psta_pkg::trade_t trade,
	input  psta_pkg::cmd_t cmd,
	output psta_pkg::stat_t st,
	output psta_pkg::result_t result
);
	import psta_pkg::*;

	localparam int AW = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int CW = $clog2(Entries + 1);

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [TimeW-1:0] gap;
		logic [TimeW-1:0] last;
		logic [VolW-1:0] vol;
		logic [NotW-1:0] notl;
		logic [PriceW-1:0] peak;
	} entry_t;

	entry_t mem [Entries];
	entry_t rd_q, ent_q;
	logic [TimeW-1:0] day_q;
	logic [CW-1:0] used_q, idx_q;
	logic [AW-1:0] slot_q;
	trade_t tr_q;
	logic bad_q;
	logic [61:0] prod_q;
	logic rd_ok_q;
	logic [1:0] stat_q;
	logic [NotW-1:0] rem_q, quo_q;
	logic [6:0] dcnt_q;
	result_t res_q;

	logic [AW-1:0] rd_addr;
	logic hit;
	logic [VolW:0] vsum;
	logic [NotW:0] nsum;
	logic [TimeW-1:0] diff;
	logic [VolW:0] rtrial;
	logic [NotW-1:0] nbits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) day_q <= DayReset;
		else if (cfg_we) day_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) used_q <= '0;
		else if (cmd.alloc) used_q <= used_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) tr_q <= trade;
		if (cmd.check) begin
			bad_q <= (tr_q.trade_time > day_q) || tr_q.quantity <= 0 || tr_q.price <= 0;
			prod_q <= 62'(tr_q.quantity[30:0]) * 62'(tr_q.price[30:0]);
		end
	end

	// search: one entry read per cycle, compared the cycle after
	assign rd_addr = cmd.search_start ? '0 : AW'(idx_q + 1'b1);
	assign hit = rd_ok_q && (idx_q < used_q) && (rd_q.key == tr_q.ticker);

	always_ff @(posedge clk) begin
		if (cmd.search_start || cmd.search_step) begin
			rd_q <= mem[rd_addr];
			idx_q <= cmd.search_start ? '0 : idx_q + 1'b1;
		end
		if (cmd.write) mem[slot_q] <= ent_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_ok_q <= 1'b0;
		else rd_ok_q <= cmd.search_start || cmd.search_step;
	end

	assign st.bad = bad_q;
	assign st.hit = hit;
	assign st.search_last = (idx_q >= used_q) || (idx_q == CW'(Entries - 1));
	assign st.table_full = (used_q == CW'(Entries));

	assign diff = tr_q.trade_time - rd_q.last;
	assign vsum = {1'b0, rd_q.vol} + (VolW+1)'(tr_q.quantity[30:0]);
	assign nsum = {1'b0, rd_q.notl} + (NotW+1)'(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			slot_q <= idx_q[AW-1:0];
			stat_q <= ST_UPDATED;
			ent_q.key <= rd_q.key;
			ent_q.gap <= (diff > rd_q.gap) ? diff : rd_q.gap;
			ent_q.last <= tr_q.trade_time;
			ent_q.vol <= vsum[VolW] ? '1 : vsum[VolW-1:0];
			ent_q.notl <= nsum[NotW] ? '1 : nsum[NotW-1:0];
			ent_q.peak <= (tr_q.price[30:0] > rd_q.peak) ? tr_q.price[30:0] : rd_q.peak;
		end else if (cmd.alloc) begin
			slot_q <= used_q[AW-1:0];
			stat_q <= ST_NEW;
			ent_q.key <= tr_q.ticker;
			ent_q.gap <= '0;
			ent_q.last <= tr_q.trade_time;
			ent_q.vol <= VolW'(tr_q.quantity[30:0]);
			ent_q.notl <= NotW'(prod_q);
			ent_q.peak <= tr_q.price[30:0];
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rtrial = {rem_q[VolW-1:0], nbits[NotW-1]} - {1'b0, ent_q.vol};
	assign nbits = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) dcnt_q <= 7'd64;
		else if (cmd.div_step) dcnt_q <= dcnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= ent_q.notl;
		end else if (cmd.div_step) begin
			if (!rtrial[VolW] || rem_q[VolW-1]) begin
				rem_q <= NotW'(rtrial[VolW-1:0]);
				quo_q <= {quo_q[NotW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NotW-2:0], quo_q[NotW-1]};
				quo_q <= {quo_q[NotW-2:0], 1'b0};
			end
		end
	end

	assign st.div_done = (dcnt_q == 7'd0);

	// quotient only lands for trades that ran the divider
	always_ff @(posedge clk) begin
		if (cmd.set_reject || cmd.set_full) begin
			res_q <= '0;
			res_q.status <= cmd.set_reject ? ST_INVALID : ST_FULL;
			res_q.ticker_out <= tr_q.ticker;
		end else if (cmd.div_start) begin
			res_q.status <= stat_q;
			res_q.ticker_out <= tr_q.ticker;
			res_q.largest_gap <= ent_q.gap;
			res_q.volume_total <= ent_q.vol;
			res_q.top_price <= ent_q.peak;
		end else if (st.div_done && !cmd.out_load &&
				(res_q.status == ST_UPDATED || res_q.status == ST_NEW)) begin
			res_q.weighted_price <= (ent_q.vol == '0) ? '0 :
				(|quo_q[NotW-1:PriceW]) ? '1 : quo_q[PriceW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) result <= res_q;
	end

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(Entries)) else $error("fill count overflow");
	a_alloc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !st.table_full) else $error("alloc when full");
	a_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> dcnt_q == 7'd64) else $error("divider not started");
`endif
endmodule

/* test/tb_per_symbol_trade_aggregator.sv */
// Self-checking testbench for per_symbol_trade_aggregator: drives trades, predicts
// each per-symbol result, and compares the results field by field in transfer order.
// Depends on psta_pkg and the per_symbol_trade_aggregator RTL.
module tb_per_symbol_trade_aggregator;
	timeunit 1ns;
	timeprecision 1ps;
	import psta_pkg::*;

	localparam int Entries = 256;
	localparam logic [36:0] TimeMax = 37'h1F_FFFF_FFFF;
	localparam logic [47:0] VolMax = 48'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [36:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	trade_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	result_t out_data;

	per_symbol_trade_aggregator #(.TABLE_ENTRIES(Entries)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the symbol table
	logic [36:0] day_len;
	logic sym_valid [Entries];
	logic [23:0] sym_key [Entries];
	logic [36:0] sym_gap [Entries];
	logic [36:0] sym_last [Entries];
	logic [47:0] sym_vol [Entries];
	logic [63:0] sym_notional [Entries];
	logic [30:0] sym_peak [Entries];
	int syms_used;

	result_t stats_q[$];
	int errors = 0;
	bit quiet = 0;
	int ready_hold = 0;
	logic [36:0] clock_us = '0;
	logic [23:0] pool [24];

	function automatic int find_symbol(logic [23:0] key);
		for (int i = 0; i < syms_used; i++)
			if (sym_valid[i] && sym_key[i] == key) return i;
		return -1;
	endfunction

	function automatic result_t trade_stats(trade_t t);
		result_t r;
		int slot;
		logic [63:0] q, p, prod, wp;
		logic [48:0] vsum;
		logic [64:0] nsum;
		logic [36:0] diff;
		r = '0;
		r.ticker_out = t.ticker;
		if (t.trade_time > day_len || t.quantity <= 0 || t.price <= 0) begin
			r.status = ST_INVALID;
			return r;
		end
		q = {33'd0, t.quantity[30:0]};
		p = {33'd0, t.price[30:0]};
		prod = p * q;
		slot = find_symbol(t.ticker);
		if (slot < 0) begin
			if (syms_used >= Entries) begin
				r.status = ST_FULL;
				return r;
			end
			slot = syms_used;
			syms_used++;
			sym_valid[slot] = 1'b1;
			sym_key[slot] = t.ticker;
			sym_gap[slot] = '0;
			sym_last[slot] = t.trade_time;
			sym_vol[slot] = q[47:0];
			sym_notional[slot] = prod;
			sym_peak[slot] = p[30:0];
			r.status = ST_NEW;
		end else begin
			diff = t.trade_time - sym_last[slot];
			if (diff > sym_gap[slot]) sym_gap[slot] = diff;
			if (p[30:0] > sym_peak[slot]) sym_peak[slot] = p[30:0];
			sym_last[slot] = t.trade_time;
			vsum = {1'b0, sym_vol[slot]} + {1'b0, q[47:0]};
			sym_vol[slot] = vsum[48] ? VolMax : vsum[47:0];
			nsum = {1'b0, sym_notional[slot]} + {1'b0, prod};
			sym_notional[slot] = nsum[64] ? '1 : nsum[63:0];
			r.status = ST_UPDATED;
		end
		wp = sym_notional[slot] / {16'd0, sym_vol[slot]};
		if (wp > 64'h7FFF_FFFF) wp = 64'h7FFF_FFFF;
		r.largest_gap = sym_gap[slot];
		r.volume_total = sym_vol[slot];
		r.weighted_price = wp[30:0];
		r.top_price = sym_peak[slot];
		return r;
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		result_t e;
		if (out_valid && out_ready) begin
			if (stats_q.size() == 0) begin
				report("unexpected result", out_data.ticker_out, 0);
			end else begin
				e = stats_q.pop_front();
				if (out_data.status !== e.status) report("status", out_data.status, e.status);
				if (out_data.ticker_out !== e.ticker_out)
					report("ticker_out", out_data.ticker_out, e.ticker_out);
				if (out_data.largest_gap !== e.largest_gap)
					report("largest_gap", out_data.largest_gap, e.largest_gap);
				if (out_data.volume_total !== e.volume_total)
					report("volume_total", out_data.volume_total, e.volume_total);
				if (out_data.weighted_price !== e.weighted_price)
					report("weighted_price", out_data.weighted_price, e.weighted_price);
				if (out_data.top_price !== e.top_price)
					report("top_price", out_data.top_price, e.top_price);
			end
		end
	end

	// receiver: random stall bursts, plus a long hold when requested
	always @(negedge clk) begin
		static int burst = 0;
		if (ready_hold > 0) begin
			out_ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (burst > 0) begin
			out_ready <= 1'b0;
			burst <= burst - 1;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			burst <= $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_trade(trade_t t);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = t;
		do @(posedge clk); while (!in_ready);
		stats_q.push_back(trade_stats(t));
	endtask

	task automatic trade(logic [36:0] tm, logic [23:0] key, logic [31:0] qty,
			logic [31:0] px);
		trade_t t;
		t.trade_time = tm;
		t.ticker = key;
		t.quantity = qty;
		t.price = px;
		send_trade(t);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (stats_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_day_length(logic [36:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		day_len = v;
	endtask

	// well-formed trade on a pool symbol with a mostly rising clock
	task automatic random_trade();
		logic [31:0] qty, px;
		case ($urandom_range(0, 9))
			0: clock_us = clock_us - $urandom_range(0, 1000);
			1: clock_us = $urandom_range(0, 1000);
			default: clock_us = clock_us + $urandom_range(0, 1 << $urandom_range(0, 24));
		endcase
		if (clock_us > day_len) clock_us = $urandom_range(0, 5000);
		qty = $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
		px = $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
		if (qty == 0) qty = 1;
		if (px == 0) px = 1;
		trade(clock_us, pool[$urandom_range(0, 23)], qty, px);
	endtask

	task automatic noise_trade();
		logic [36:0] tm;
		tm = 37'({$urandom(), $urandom()});
		case ($urandom_range(0, 2))
			0: trade(tm, 24'($urandom()), $urandom(), $urandom());
			1: trade(clock_us, pool[$urandom_range(0, 23)], -$urandom_range(0, 1000), 5);
			default: trade(clock_us, 24'($urandom()), 7, $urandom() | 32'h8000_0000);
		endcase
	endtask

	task automatic test_field_extremes();
		trade(0, 24'h000000, 1, 1);
		trade(day_len, 24'h000000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		trade(day_len + 1, 24'h000000, 1, 1);
		trade(TimeMax, 24'hFFFFFF, 1, 1);
		trade(10, 24'hFFFFFF, 0, 5);
		trade(10, 24'hFFFFFF, 32'hFFFF_FFFF, 5);
		trade(10, 24'hFFFFFF, 32'h8000_0000, 5);
		trade(10, 24'hFFFFFF, 5, 0);
		trade(10, 24'hFFFFFF, 5, 32'h8000_0000);
		trade(10, 24'hFFFFFF, 3, 100);
		trade(2000, 24'hFFFFFF, 2, 50);
		// earlier timestamp: the gap wraps modulo 2^37
		trade(5, 24'hFFFFFF, 2, 300);
		trade(7, 24'hFFFFFF, 4, 1);
	endtask

	task automatic test_notional_saturation();
		for (int i = 0; i < 6; i++)
			trade(100 + i, 24'h534154, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		trade(200, 24'h534154, 1, 1);
	endtask

	task automatic test_day_length_extremes();
		write_day_length(0);
		trade(0, 24'h5A4552, 9, 9);
		trade(1, 24'h5A4552, 9, 9);
		write_day_length(TimeMax);
		trade(TimeMax, 24'h4D4158, 9, 9);
		trade(0, 24'h4D4158, 9, 9);
		trade(37'h10_0000_0000, 24'h4D4158, 9, 9);
		write_day_length(DayReset);
	endtask

	task automatic test_random_mix(int n);
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 9) == 0) noise_trade();
			else random_trade();
	endtask

	task automatic test_output_backpressure();
		@(negedge clk);
		ready_hold = 400;
		test_random_mix(8);
	endtask

	task automatic test_table_full();
		logic [23:0] key;
		int n;
		n = 0;
		while (syms_used < Entries) begin
			key = 24'(24'h400000 + n);
			n++;
			if (find_symbol(key) < 0) trade(n, key, n, 3);
		end
		for (int i = 0; i < 4; i++) trade(50, 24'(24'h7A0000 + i), 1, 1);
		for (int i = 0; i < 4; i++) trade(60, sym_key[$urandom_range(0, Entries - 1)], 2, 2);
		trade(70, 24'h7A0000, -1, 1);
	endtask

	initial begin
		day_len = DayReset;
		syms_used = 0;
		for (int i = 0; i < Entries; i++) sym_valid[i] = 1'b0;
		for (int i = 0; i < 24; i++) pool[i] = 24'($urandom());
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_notional_saturation();
		test_day_length_extremes();
		test_output_backpressure();
		test_random_mix(60);
		// sender holds until the pipeline is empty
		wait_drained();
		test_random_mix(60);
		write_day_length(37'd1_000_000);
		test_random_mix(30);
		write_day_length(DayReset);
		test_table_full();
		quiet = 1;
		test_random_mix(25);

		wait_drained();
		repeat (400) @(posedge clk);
		if (errors == 0 && stats_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#40ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
